/* hw/rtl/tch_pkg.sv */
// Shared types, widths and CORDIC helpers for the tilt-compensated heading block.
// Used by every cell module and by the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package tch_pkg;

   // Sensor sample width and number of CORDIC iterations
   localparam int SAMPLE_WIDTH = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int TAB_LEN      = 24;
   localparam int STEPS        = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

   // Datapath widths: Q.30 vectors, wide CORDIC x/y, Q.28 angles
   localparam int QW        = 32;
   localparam int XW        = 40;
   localparam int ZW        = 34;
   localparam int IDXW      = 5;
   localparam int SQW       = 63;
   localparam int ISQ_STEPS = 31;

   localparam int REQ_W = ((6 * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_W = 48;

   localparam logic signed [ZW-1:0] HALF_PI  = ZW'(64'sd421657428);
   localparam logic signed [XW-1:0] GAIN_INV = XW'(64'sd652032874);
   localparam logic signed [QW-1:0] ONE_Q30  = QW'(64'sd1073741824);

   localparam logic signed [18:0] PITCH_LIM = 19'sd25736;
   localparam logic signed [18:0] ROLL_LIM  = 19'sd12868;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
      logic [IDXW-1:0]      idx;
   } vec_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic [IDXW-1:0]      idx;
   } rot_type;

   typedef struct packed {
      logic [SQW-1:0]  n;
      logic [SQW-1:0]  r;
      logic [IDXW-1:0] idx;
   } sqrt_type;

   // atan(2^-i) in Q.28, rounded to nearest
   function automatic logic signed [ZW-1:0] atan_lut(input logic [IDXW-1:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         5'd0:    v = ZW'(64'sd210828714);
         5'd1:    v = ZW'(64'sd124459457);
         5'd2:    v = ZW'(64'sd65760959);
         5'd3:    v = ZW'(64'sd33381290);
         5'd4:    v = ZW'(64'sd16755422);
         5'd5:    v = ZW'(64'sd8385879);
         5'd6:    v = ZW'(64'sd4193963);
         5'd7:    v = ZW'(64'sd2097109);
         5'd8:    v = ZW'(64'sd1048571);
         5'd9:    v = ZW'(64'sd524287);
         5'd10:   v = ZW'(64'sd262144);
         5'd11:   v = ZW'(64'sd131072);
         5'd12:   v = ZW'(64'sd65536);
         5'd13:   v = ZW'(64'sd32768);
         5'd14:   v = ZW'(64'sd16384);
         5'd15:   v = ZW'(64'sd8192);
         5'd16:   v = ZW'(64'sd4096);
         5'd17:   v = ZW'(64'sd2048);
         5'd18:   v = ZW'(64'sd1024);
         5'd19:   v = ZW'(64'sd512);
         5'd20:   v = ZW'(64'sd256);
         5'd21:   v = ZW'(64'sd128);
         5'd22:   v = ZW'(64'sd64);
         5'd23:   v = ZW'(64'sd32);
         default: v = '0;
      endcase
      return v;
   endfunction

   // Place a raw sample in the top bits of the word, which moves it to Q.30
   function automatic logic signed [QW-1:0] sample_q30(input logic [SAMPLE_WIDTH-1:0] raw);
      return {raw, {(QW - SAMPLE_WIDTH){1'b0}}};
   endfunction

   // Quadrant fold ahead of the vectoring chain
   function automatic vec_type vec_pre(input logic signed [XW-1:0] y,
                                       input logic signed [XW-1:0] x);
      vec_type v;
      v.x    = x;
      v.y    = y;
      v.z    = '0;
      v.idx  = '0;
      v.zero = (x == '0) && (y == '0);
      if (x < 0) begin
         if (y >= 0) begin
            v.x = y;
            v.y = -x;
            v.z = HALF_PI;
         end else begin
            v.x = -y;
            v.y = x;
            v.z = -HALF_PI;
         end
      end
      return v;
   endfunction

   // Quadrant fold ahead of the rotation chain
   function automatic rot_type rot_pre(input logic signed [ZW-1:0] z);
      rot_type r;
      r.idx = '0;
      if (z > HALF_PI) begin
         r.z = z - HALF_PI;
         r.x = '0;
         r.y = GAIN_INV;
      end else if (z < -HALF_PI) begin
         r.z = z + HALF_PI;
         r.x = '0;
         r.y = -GAIN_INV;
      end else begin
         r.z = z;
         r.x = GAIN_INV;
         r.y = '0;
      end
      return r;
   endfunction

   // Q.28 angle to Q3.13, rounded half up and saturated
   function automatic logic signed [18:0] angle_out(input logic signed [ZW-1:0] z,
                                                    input logic signed [18:0] lim);
      logic signed [ZW:0] s;
      logic signed [18:0] v;
      s = {z[ZW-1], z} + (ZW+1)'(1 << 14);
      v = s[ZW-1:15];
      if (v > lim) begin
         v = lim;
      end else if (v < -lim) begin
         v = -lim;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/tch_isqrt_cell.sv */
// One digit step of the pipelined integer square root.
// Depends on tch_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tch_isqrt_cell (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire tch_pkg::sqrt_type c_in,
   output tch_pkg::sqrt_type      c_out
);
   import tch_pkg::*;

   sqrt_type       out_ff;
   sqrt_type       out_in;
   logic [SQW-1:0] bit_w;
   logic [SQW-1:0] trial;

   // Try one result bit, restore when it does not fit
   always_comb begin
      bit_w  = SQW'(1) << (7'd60 - {c_in.idx, 1'b0});
      trial  = c_in.r + bit_w;
      out_in = c_in;
      out_in.idx = c_in.idx + 1'b1;
      if (c_in.n >= trial) begin
         out_in.n = c_in.n - trial;
         out_in.r = (c_in.r >> 1) + bit_w;
      end else begin
         out_in.r = c_in.r >> 1;
      end
   end

   // Advance with the pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign c_out = out_ff;
endmodule
`default_nettype wire

/* hw/rtl/tch_vec_cell.sv */
// One CORDIC vectoring iteration (arctangent), registered.
// Depends on tch_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tch_vec_cell (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire tch_pkg::vec_type c_in,
   output tch_pkg::vec_type      c_out
);
   import tch_pkg::*;

   vec_type              out_ff;
   vec_type              out_in;
   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;

   // Drive y toward zero, accumulate the angle
   always_comb begin
      xs     = c_in.x >>> c_in.idx;
      ys     = c_in.y >>> c_in.idx;
      out_in = c_in;
      out_in.idx = c_in.idx + 1'b1;
      if (c_in.y < 0) begin
         out_in.x = c_in.x - ys;
         out_in.y = c_in.y + xs;
         out_in.z = c_in.z - atan_lut(c_in.idx);
      end else begin
         out_in.x = c_in.x + ys;
         out_in.y = c_in.y - xs;
         out_in.z = c_in.z + atan_lut(c_in.idx);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign c_out = out_ff;
endmodule
`default_nettype wire

/* hw/rtl/tch_rot_cell.sv */
// One CORDIC rotation iteration (sine and cosine), registered.
// Depends on tch_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tch_rot_cell (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire tch_pkg::rot_type c_in,
   output tch_pkg::rot_type      c_out
);
   import tch_pkg::*;

   rot_type              out_ff;
   rot_type              out_in;
   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;

   // Drive the residual angle toward zero
   always_comb begin
      xs     = c_in.x >>> c_in.idx;
      ys     = c_in.y >>> c_in.idx;
      out_in = c_in;
      out_in.idx = c_in.idx + 1'b1;
      if (c_in.z >= 0) begin
         out_in.x = c_in.x - ys;
         out_in.y = c_in.y + xs;
         out_in.z = c_in.z - atan_lut(c_in.idx);
      end else begin
         out_in.x = c_in.x + ys;
         out_in.y = c_in.y - xs;
         out_in.z = c_in.z + atan_lut(c_in.idx);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign c_out = out_ff;
endmodule
`default_nettype wire

/* hw/rtl/tilt_compensated_heading.sv */
// Tilt-compensated compass heading: pitch, roll and yaw from accel and mag vectors.
// Chains tch_isqrt_cell, tch_vec_cell and tch_rot_cell; depends on tch_pkg.
//
// Usage:
//   req channel: one word holds accel x/y/z and mag x/y/z, each SAMPLE_WIDTH
//   bits, Q1.(SAMPLE_WIDTH-2) signed. rsp channel: one word per request with
//   pitch, roll and heading in Q3.13 radians.
//   Throughput: one word per cycle unless the output stalls. The whole datapath
//   is a single chain of registered cells: 31 square-root digit cells, then
//   three CORDIC chains of STEPS cells each (CORDIC_STEPS capped at TAB_LEN;
//   pitch/roll arctangent, sine/cosine, heading arctangent), with fold,
//   multiply and sum stages in between.
//   Stall: while rsp_tvalid is high and rsp_tready low the whole chain holds,
//   and req_tready drops; a waiting result is held unchanged. req_tready is
//   high whenever the output register is empty or being taken.
//   Reset: clears every valid bit in the chain; words in flight are dropped.
`timescale 1ns / 1ps
`default_nettype none
module tilt_compensated_heading (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z (lowest bits first)
   input  wire logic [tch_pkg::REQ_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // pitch_angle[15:0], roll_angle[30:16], heading_angle[46:31], zero pad
   output logic [tch_pkg::RSP_W-1:0]      rsp_tdata
);
   import tch_pkg::*;

   localparam int N = STEPS;
   localparam int SW = SAMPLE_WIDTH;

   typedef struct packed {
      logic                 valid;
      logic signed [QW-1:0] ax;
      logic signed [QW-1:0] ay;
      logic signed [QW-1:0] az;
      logic signed [QW-1:0] mx;
      logic signed [QW-1:0] my;
      logic signed [QW-1:0] mz;
   } side_a_type;

   typedef struct packed {
      logic                 valid;
      logic signed [QW-1:0] mx;
      logic signed [QW-1:0] my;
      logic signed [QW-1:0] mz;
   } side_b_type;

   typedef struct packed {
      logic                 valid;
      logic signed [QW-1:0] mx;
      logic signed [QW-1:0] my;
      logic signed [QW-1:0] mz;
      logic signed [ZW-1:0] pitch;
      logic signed [ZW-1:0] roll;
   } side_c_type;

   typedef struct packed {
      logic                 valid;
      logic signed [ZW-1:0] pitch;
      logic signed [ZW-1:0] roll;
   } side_d_type;

   typedef struct packed {
      logic                 valid;
      logic signed [ZW-1:0] pitch;
      logic signed [ZW-1:0] roll;
      logic signed [33:0]   a;
      logic signed [33:0]   b;
      logic signed [33:0]   c;
      logic signed [33:0]   d;
      logic signed [33:0]   e;
      logic signed [QW-1:0] rs;
      logic signed [QW-1:0] rc;
   } m1_type;

   typedef struct packed {
      logic                 valid;
      logic signed [ZW-1:0] pitch;
      logic signed [ZW-1:0] roll;
      logic signed [34:0]   hy;
      logic signed [33:0]   f;
      logic signed [33:0]   d;
      logic signed [33:0]   h;
   } m2_type;

   logic en;

   side_a_type s1_ff, s1_in;
   side_a_type sa_ff [0:ISQ_STEPS];
   sqrt_type   sq_d  [0:ISQ_STEPS];
   sqrt_type   sq0_ff;
   logic signed [2*QW-1:0] ax_sq;

   side_b_type sb_ff [0:N];
   vec_type    vp_d  [0:N];
   vec_type    vr_d  [0:N];
   vec_type    vp0_ff, vr0_ff;

   side_c_type sc_ff [0:N];
   rot_type    rp_d  [0:N];
   rot_type    rr_d  [0:N];
   rot_type    rp0_ff, rr0_ff;
   logic signed [ZW-1:0] pitch_w, roll_w;

   m1_type m1_ff, m1_in;
   m2_type m2_ff, m2_in;
   side_d_type s3_ff;
   logic signed [XW-1:0] hy_ff, hx_ff;
   logic signed [XW-1:0] hx_in;

   side_d_type sd_ff [0:N];
   vec_type    vy_d  [0:N];
   vec_type    vy0_ff;

   logic                 rsp_tvalid_ff;
   logic [RSP_W-1:0]     rsp_tdata_ff, rsp_tdata_in;
   logic signed [ZW-1:0] yaw_w;

   logic signed [2*QW-1:0]   p_a, p_b, p_c, p_d, p_e;
   logic signed [34+QW-1:0]  p_f, p_h;

   // Move the whole chain unless a result waits to be taken
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // Stage 1: unpack samples, clamp ax to plus or minus one
   always_comb begin
      s1_in.valid = req_tvalid;
      s1_in.ax    = sample_q30(req_tdata[SW-1:0]);
      s1_in.ay    = sample_q30(req_tdata[2*SW-1:SW]);
      s1_in.az    = sample_q30(req_tdata[3*SW-1:2*SW]);
      s1_in.mx    = sample_q30(req_tdata[4*SW-1:3*SW]);
      s1_in.my    = sample_q30(req_tdata[5*SW-1:4*SW]);
      s1_in.mz    = sample_q30(req_tdata[6*SW-1:5*SW]);
      if (s1_in.ax > ONE_Q30) begin
         s1_in.ax = ONE_Q30;
      end else if (s1_in.ax < -ONE_Q30) begin
         s1_in.ax = -ONE_Q30;
      end
   end

   assign ax_sq = s1_ff.ax * s1_ff.ax;

   // Stage 2: radicand 1 - ax^2, then square-root chain with side data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         for (int k = 0; k <= ISQ_STEPS; k++) begin
            sa_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         s1_ff  <= s1_in;
         sa_ff[0] <= s1_ff;
         for (int k = 0; k < ISQ_STEPS; k++) begin
            sa_ff[k+1] <= sa_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq0_ff.n   <= (SQW'(1) << 60) - ax_sq[SQW-1:0];
         sq0_ff.r   <= '0;
         sq0_ff.idx <= '0;
      end
   end

   assign sq_d[0] = sq0_ff;

   for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isqrt
      tch_isqrt_cell u_cell (
         .clock (clock),
         .en    (en),
         .c_in  (sq_d[k]),
         .c_out (sq_d[k+1])
      );
   end

   // Fold quadrants for pitch = atan2(ay, az) and roll = atan2(-ax, root)
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= N; k++) begin
            sb_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         sb_ff[0].valid <= sa_ff[ISQ_STEPS].valid;
         sb_ff[0].mx    <= sa_ff[ISQ_STEPS].mx;
         sb_ff[0].my    <= sa_ff[ISQ_STEPS].my;
         sb_ff[0].mz    <= sa_ff[ISQ_STEPS].mz;
         for (int k = 0; k < N; k++) begin
            sb_ff[k+1] <= sb_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vp0_ff <= vec_pre(XW'(sa_ff[ISQ_STEPS].ay), XW'(sa_ff[ISQ_STEPS].az));
         vr0_ff <= vec_pre(-XW'(sa_ff[ISQ_STEPS].ax),
                           XW'({1'b0, sq_d[ISQ_STEPS].r[QW-2:0]}));
      end
   end

   assign vp_d[0] = vp0_ff;
   assign vr_d[0] = vr0_ff;

   for (genvar k = 0; k < N; k++) begin : g_vec_pr
      tch_vec_cell u_pitch (
         .clock (clock),
         .en    (en),
         .c_in  (vp_d[k]),
         .c_out (vp_d[k+1])
      );
      tch_vec_cell u_roll (
         .clock (clock),
         .en    (en),
         .c_in  (vr_d[k]),
         .c_out (vr_d[k+1])
      );
   end

   assign pitch_w = vp_d[N].zero ? '0 : vp_d[N].z;
   assign roll_w  = vr_d[N].zero ? '0 : vr_d[N].z;

   // Fold angles for the sine/cosine chains
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= N; k++) begin
            sc_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         sc_ff[0].valid <= sb_ff[N].valid;
         sc_ff[0].mx    <= sb_ff[N].mx;
         sc_ff[0].my    <= sb_ff[N].my;
         sc_ff[0].mz    <= sb_ff[N].mz;
         sc_ff[0].pitch <= pitch_w;
         sc_ff[0].roll  <= roll_w;
         for (int k = 0; k < N; k++) begin
            sc_ff[k+1] <= sc_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rp0_ff <= rot_pre(pitch_w);
         rr0_ff <= rot_pre(roll_w);
      end
   end

   assign rp_d[0] = rp0_ff;
   assign rr_d[0] = rr0_ff;

   for (genvar k = 0; k < N; k++) begin : g_rot
      tch_rot_cell u_pitch (
         .clock (clock),
         .en    (en),
         .c_in  (rp_d[k]),
         .c_out (rp_d[k+1])
      );
      tch_rot_cell u_roll (
         .clock (clock),
         .en    (en),
         .c_in  (rr_d[k]),
         .c_out (rr_d[k+1])
      );
   end

   // First products: cos is x, sin is y of each rotation chain
   always_comb begin
      p_a = sc_ff[N].mx * $signed(rr_d[N].x[QW-1:0]);
      p_b = sc_ff[N].mz * $signed(rr_d[N].y[QW-1:0]);
      p_c = sc_ff[N].mx * $signed(rp_d[N].y[QW-1:0]);
      p_d = sc_ff[N].my * $signed(rp_d[N].x[QW-1:0]);
      p_e = sc_ff[N].mz * $signed(rp_d[N].y[QW-1:0]);
      m1_in.valid = sc_ff[N].valid;
      m1_in.pitch = sc_ff[N].pitch;
      m1_in.roll  = sc_ff[N].roll;
      m1_in.a     = p_a[63:30];
      m1_in.b     = p_b[63:30];
      m1_in.c     = p_c[63:30];
      m1_in.d     = p_d[63:30];
      m1_in.e     = p_e[63:30];
      m1_in.rs    = rr_d[N].y[QW-1:0];
      m1_in.rc    = rr_d[N].x[QW-1:0];
   end

   // Second products and the y sum
   always_comb begin
      p_f = m1_ff.c * m1_ff.rs;
      p_h = m1_ff.e * m1_ff.rc;
      m2_in.valid = m1_ff.valid;
      m2_in.pitch = m1_ff.pitch;
      m2_in.roll  = m1_ff.roll;
      m2_in.hy    = 35'(m1_ff.a) + 35'(m1_ff.b);
      m2_in.f     = p_f[63:30];
      m2_in.d     = m1_ff.d;
      m2_in.h     = p_h[63:30];
   end

   assign hx_in = XW'(m2_ff.f) + XW'(m2_ff.d) - XW'(m2_ff.h);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff.valid <= 1'b0;
         m2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (en) begin
         m1_ff       <= m1_in;
         m2_ff       <= m2_in;
         s3_ff.valid <= m2_ff.valid;
         s3_ff.pitch <= m2_ff.pitch;
         s3_ff.roll  <= m2_ff.roll;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hy_ff  <= XW'(m2_ff.hy);
         hx_ff  <= hx_in;
         vy0_ff <= vec_pre(hy_ff, hx_ff);
      end
   end

   // Heading arctangent chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= N; k++) begin
            sd_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         sd_ff[0] <= s3_ff;
         for (int k = 0; k < N; k++) begin
            sd_ff[k+1] <= sd_ff[k];
         end
      end
   end

   assign vy_d[0] = vy0_ff;

   for (genvar k = 0; k < N; k++) begin : g_vec_y
      tch_vec_cell u_yaw (
         .clock (clock),
         .en    (en),
         .c_in  (vy_d[k]),
         .c_out (vy_d[k+1])
      );
   end

   assign yaw_w = vy_d[N].zero ? '0 : vy_d[N].z;

   // Output register: round, saturate and pack
   always_comb begin
      logic signed [18:0] pv, rv, hv;
      pv = angle_out(sd_ff[N].pitch, PITCH_LIM);
      rv = angle_out(sd_ff[N].roll, ROLL_LIM);
      hv = angle_out(yaw_w, PITCH_LIM);
      rsp_tdata_in = {1'b0, hv[15:0], rv[14:0], pv[15:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= sd_ff[N].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
endmodule
`default_nettype wire

/* hw/rtl/tch_checker.sv */
// Port-level assertions for tilt_compensated_heading, attached by bind.
// Depends on tch_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tch_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tvalid,
   input wire logic                      req_tready,
   input wire logic [tch_pkg::REQ_W-1:0] req_tdata,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [tch_pkg::RSP_W-1:0] rsp_tdata
);
   import tch_pkg::*;

   logic signed [14:0] roll_v;
   assign roll_v = rsp_tdata[30:16];

   // Nothing leaves right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Input side follows the output register
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not track output register");

   // Stalled word stays
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp word changed");

   // Roll stays within half pi, pad bit stays zero
   a_roll: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (roll_v <= 15'sd12868) && (roll_v >= -15'sd12868) && !rsp_tdata[47])
      else $error("roll out of range");

endmodule

bind tilt_compensated_heading tch_checker u_tch_checker (.*);
`default_nettype wire
